>>> src/crvr_pkg.sv
package crvr_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 16;
  localparam int PHASE_BITS    = FRAC_BITS + 3;
  // intermediate cubic terms stay below 2^(SAMPLE_BITS+5) in magnitude
  localparam int COEF_BITS     = SAMPLE_BITS + 6;
  localparam int PROD_BITS     = COEF_BITS + FRAC_BITS + 1;
  localparam int MAX_RESULTS   = 16;
  localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);
  localparam int NUM_REGS      = 2;
  localparam int CFG_IDX_BITS  = $clog2(NUM_REGS);
  localparam int CFG_DATA_BITS = PHASE_BITS;
  localparam int DATA_BITS     = 2 * SAMPLE_BITS;
  localparam int TDATA_BITS    = ((DATA_BITS + 7) / 8) * 8;

  localparam logic [PHASE_BITS-1:0] PHASE_ONE =
    {{(PHASE_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PHASE_BITS-1:0] STEP_RESET = PHASE_ONE;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEP   = 1'b0,
    REG_STEREO = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_CUBIC,
    OP_QUAD,
    OP_FINAL
  } mac_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_L0,
    ST_L1,
    ST_L2,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic    en;
    mac_op_e op;
    logic    right;
  } mac_ctrl_t;

  typedef struct packed {
    logic      ready;
    logic      prep;
    logic      hold_left;
    logic      emit;
    mac_ctrl_t mac;
  } seq_ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic run_go;
    logic slot_free;
    logic run_last;
  } seq_status_t;

  localparam logic signed [COEF_BITS:0] SAT_HI =
    {{(COEF_BITS-SAMPLE_BITS+2){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS:0] SAT_LO = ~SAT_HI;

  function automatic sample_t sat_sample(input logic signed [COEF_BITS:0] v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/crvr_mac.sv
module crvr_mac (
  input  logic                                 clk_i,
  input  crvr_pkg::mac_ctrl_t                  ctrl_i,
  input  logic [crvr_pkg::FRAC_BITS-1:0]       t_i,
  input  crvr_pkg::coef_t                      a0_i,
  input  crvr_pkg::coef_t                      a1_i,
  input  crvr_pkg::coef_t                      a2_i,
  input  crvr_pkg::sample_t                    d1_i,
  output crvr_pkg::coef_t                      acc_o
);
  import crvr_pkg::*;

  coef_t                       acc_q, acc_d;
  coef_t                       mul_a;
  coef_t                       addend;
  logic                        is_final;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS:0]   rnd;
  logic signed [PROD_BITS:0]   prod_rnd;
  coef_t                       shift_f;
  coef_t                       shift_f1;

  assign is_final = (ctrl_i.op == OP_FINAL);
  assign mul_a    = (ctrl_i.op == OP_CUBIC) ? a0_i : acc_q;
  assign prod     = PROD_BITS'(mul_a) * PROD_BITS'($signed({1'b0, t_i}));

  // half of 2^(F+1) for round half up on the last step
  assign rnd      = {{(PROD_BITS-FRAC_BITS){1'b0}}, is_final, {FRAC_BITS{1'b0}}};
  assign prod_rnd = $signed({prod[PROD_BITS-1], prod}) + rnd;

  // slices are floor shifts taken modulo 2^COEF_BITS
  assign shift_f  = $signed(prod_rnd[FRAC_BITS +: COEF_BITS]);
  assign shift_f1 = $signed(prod_rnd[FRAC_BITS+1 +: COEF_BITS]);

  always_comb begin
    unique case (ctrl_i.op)
      OP_CUBIC: addend = a1_i;
      OP_QUAD:  addend = a2_i;
      OP_FINAL: addend = COEF_BITS'(d1_i);
      default:  addend = '0;
    endcase
    acc_d = (is_final ? shift_f1 : shift_f) + addend;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

>>> src/crvr_seq.sv
module crvr_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crvr_pkg::seq_status_t status_i,
  output crvr_pkg::seq_ctrl_t   ctrl_o
);
  import crvr_pkg::*;

  seq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (status_i.in_fire) state_d = ST_PREP;
      ST_PREP: state_d = status_i.run_go ? ST_L0 : ST_IDLE;
      ST_L0:   state_d = ST_L1;
      ST_L1:   state_d = ST_L2;
      ST_L2:   state_d = ST_R0;
      ST_R0:   state_d = ST_R1;
      ST_R1:   state_d = ST_R2;
      ST_R2:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.slot_free) begin
          state_d = status_i.run_last ? ST_IDLE : ST_L0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.mac.op    = OP_CUBIC;
    unique case (state_q)
      ST_IDLE: ctrl_o.ready = 1'b1;
      ST_PREP: ctrl_o.prep  = 1'b1;
      ST_L0: begin
        ctrl_o.mac.en = 1'b1;
        ctrl_o.mac.op = OP_CUBIC;
      end
      ST_L1: begin
        ctrl_o.mac.en = 1'b1;
        ctrl_o.mac.op = OP_QUAD;
      end
      ST_L2: begin
        ctrl_o.mac.en = 1'b1;
        ctrl_o.mac.op = OP_FINAL;
      end
      ST_R0: begin
        // accumulator still holds the left result here
        ctrl_o.hold_left = 1'b1;
        ctrl_o.mac.en    = 1'b1;
        ctrl_o.mac.op    = OP_CUBIC;
        ctrl_o.mac.right = 1'b1;
      end
      ST_R1: begin
        ctrl_o.mac.en    = 1'b1;
        ctrl_o.mac.op    = OP_QUAD;
        ctrl_o.mac.right = 1'b1;
      end
      ST_R2: begin
        ctrl_o.mac.en    = 1'b1;
        ctrl_o.mac.op    = OP_FINAL;
        ctrl_o.mac.right = 1'b1;
      end
      ST_EMIT: ctrl_o.emit = status_i.slot_free;
      default: ctrl_o.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/catmull_rom_variable_rate_resampler.sv
// channel  | dir | handshake             | contents
// s_axis   | in  | tvalid/tready         | one stereo source sample
// m_axis   | out | tvalid/tready, tlast  | one interpolated sample, tlast on final of run
// cfg      | in  | cfg_we_i              | step and stereo_out registers
//
// an input passes through accept and coefficient setup, then each result takes
// six passes through the single multiply-add unit (three per channel) and one emit,
// and the emit waits while the output register is held by tready.
// s_axis_tready is high only while the sequencer is idle; a finished result waits
// in the output register while the next one is computed.
// reset clears windows, phase, registers to defaults and the output valid.
module catmull_rom_variable_rate_resampler (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [crvr_pkg::TDATA_BITS-1:0]       s_axis_tdata,  // in_left, in_right
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [crvr_pkg::TDATA_BITS-1:0]       m_axis_tdata,  // out_left, out_right
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_we_i,
  input  logic [crvr_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [crvr_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import crvr_pkg::*;

  typedef struct packed {
    coef_t a0;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  function automatic coef_set_t make_coefs(input sample_t d0, input sample_t d1,
                                           input sample_t d2, input sample_t d3);
    coef_set_t c;
    coef_t     e0, e1, e2, e3;
    e0   = COEF_BITS'(d0);
    e1   = COEF_BITS'(d1);
    e2   = COEF_BITS'(d2);
    e3   = COEF_BITS'(d3);
    c.a0 = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
    c.a1 = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    c.a2 = e2 - e0;
    return c;
  endfunction

  seq_ctrl_t   ctrl;
  seq_status_t status;

  sample_t                win_l_q [4];
  sample_t                win_r_q [4];
  coef_set_t              coef_l_q, coef_r_q;
  logic [PHASE_BITS-1:0]  phase_q;
  logic [PHASE_BITS-1:0]  step_q;
  logic                   stereo_q;
  logic [CNT_BITS-1:0]    cnt_q;
  coef_t                  yl_q;
  sample_t                out_l_q, out_r_q;
  logic                   out_last_q;
  logic                   out_valid_q;

  logic                   in_fire;
  logic                   out_fire;
  logic [PHASE_BITS:0]    phase_sum;
  logic [PHASE_BITS-1:0]  phase_next;
  logic [CNT_BITS-1:0]    cnt_inc;
  logic                   run_last;
  coef_t                  acc;
  coef_set_t              coef_sel;
  sample_t                d1_sel;
  logic signed [COEF_BITS:0] mono_sum;
  sample_t                left_val, right_val;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = ctrl.ready;

  // next phase and whether this result closes the run
  assign phase_sum  = {1'b0, phase_q} + {1'b0, step_q};
  assign phase_next = phase_sum[PHASE_BITS] ? '1 : phase_sum[PHASE_BITS-1:0];
  assign cnt_inc    = cnt_q + CNT_BITS'(1);
  assign run_last   = !((phase_next < PHASE_ONE) && (cnt_inc < CNT_BITS'(MAX_RESULTS)));

  assign status.in_fire   = in_fire;
  assign status.run_go    = (phase_q < PHASE_ONE);
  assign status.slot_free = !out_valid_q || m_axis_tready;
  assign status.run_last  = run_last;

  crvr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign coef_sel = ctrl.mac.right ? coef_r_q : coef_l_q;
  assign d1_sel   = ctrl.mac.right ? win_r_q[1] : win_l_q[1];

  crvr_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl.mac),
    .t_i    (phase_q[FRAC_BITS-1:0]),
    .a0_i   (coef_sel.a0),
    .a1_i   (coef_sel.a1),
    .a2_i   (coef_sel.a2),
    .d1_i   (d1_sel),
    .acc_o  (acc)
  );

  // in emit the accumulator holds the right result
  assign mono_sum = $signed({yl_q[COEF_BITS-1], yl_q}) + $signed({acc[COEF_BITS-1], acc});

  always_comb begin
    if (stereo_q) begin
      left_val  = sat_sample($signed({yl_q[COEF_BITS-1], yl_q}));
      right_val = sat_sample($signed({acc[COEF_BITS-1], acc}));
    end else begin
      left_val  = sat_sample($signed({mono_sum[COEF_BITS], mono_sum[COEF_BITS:1]}));
      right_val = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        win_l_q[i] <= '0;
        win_r_q[i] <= '0;
      end
      phase_q     <= '0;
      step_q      <= STEP_RESET;
      stereo_q    <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_STEP) begin
          step_q <= cfg_data_i;
        end else if (cfg_idx_i == REG_STEREO) begin
          stereo_q <= cfg_data_i[0];
        end
      end
      if (in_fire) begin
        for (int i = 0; i < 3; i++) begin
          win_l_q[i] <= win_l_q[i+1];
          win_r_q[i] <= win_r_q[i+1];
        end
        win_l_q[3] <= s_axis_tdata[SAMPLE_BITS-1:0];
        win_r_q[3] <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        phase_q    <= (phase_q >= PHASE_ONE) ? phase_q - PHASE_ONE : '0;
        cnt_q      <= '0;
      end else if (ctrl.emit) begin
        phase_q <= phase_next;
        cnt_q   <= cnt_inc;
      end
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.prep) begin
      coef_l_q <= make_coefs(win_l_q[0], win_l_q[1], win_l_q[2], win_l_q[3]);
      coef_r_q <= make_coefs(win_r_q[0], win_r_q[1], win_r_q[2], win_r_q[3]);
    end
    if (ctrl.hold_left) begin
      yl_q <= acc;
    end
    if (ctrl.emit) begin
      out_l_q    <= left_val;
      out_r_q    <= right_val;
      out_last_q <= run_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_BITS'({out_r_q, out_l_q});
  assign m_axis_tlast  = out_last_q;

endmodule
